/* rtl/scfp_pkg.sv */
`timescale 1ns / 1ps

package scfp_pkg;

  localparam int DEF_HEADER_LEN  = 2;
  localparam int DEF_TRAILER_LEN = 2;
  localparam int DEF_MAX_PAYLOAD = 256;

  localparam int BYTE_W    = 8;
  localparam int LENGTH_W  = 16;
  localparam int POS_W     = 8;
  localparam int PATTERN_W = 32;
  localparam int EVENT_W   = 3;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [2:0] {
    PH_HEAD = 3'd0,
    PH_CMD  = 3'd1,
    PH_LEN  = 3'd2,
    PH_DATA = 3'd3,
    PH_TAIL = 3'd4
  } phase_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE    = 3'd0,
    EV_DATA    = 3'd1,
    EV_DONE    = 3'd2,
    EV_TOOLONG = 3'd3,
    EV_BADTAIL = 3'd4
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER  = 2'd0,
    REG_TRAILER = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [EVENT_W-1:0]  event_res;
    logic [BYTE_W-1:0]   command;
    logic [LENGTH_W-1:0] payload_length;
    logic [POS_W-1:0]    payload_index;
    logic [BYTE_W-1:0]   payload_byte;
  } result_t;

  // Byte idx of a pattern word, first byte in the low bits.
  function automatic logic [BYTE_W-1:0] pattern_byte(input logic [PATTERN_W-1:0] pat,
                                                     input logic [1:0] idx);
    logic [PATTERN_W-1:0] shifted;
    shifted = pat >> {idx, 3'b000};
    return shifted[BYTE_W-1:0];
  endfunction

endpackage

/* rtl/scfp_out_buf.sv */
`timescale 1ns / 1ps

module scfp_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  scfp_pkg::result_t push_data,
  output logic             out_valid,
  input  logic             out_stall,
  output scfp_pkg::result_t out_data
);
  import scfp_pkg::*;

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;
  logic    main_taken;

  assign main_taken = main_valid && !out_stall;
  assign full       = skid_valid;
  assign out_valid  = main_valid;
  assign out_data   = main_data;

  // Push is only asserted while the skid stage is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (push) begin
        if (main_valid && !main_taken) begin
          skid_valid <= 1'b1;
        end else begin
          main_valid <= 1'b1;
        end
      end else if (main_taken) begin
        main_valid <= skid_valid;
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (main_valid && !main_taken) begin
        skid_data <= push_data;
      end else begin
        main_data <= push_data;
      end
    end else if (main_taken && skid_valid) begin
      main_data <= skid_data;
    end
  end

endmodule

/* rtl/serial_command_frame_parser.sv */
`timescale 1ns / 1ps

// Serial command frame parser. Each input item is one received byte on rx_byte,
// handed over with in_valid and held off by in_stall. Every accepted byte gives
// exactly one result item on the output channel (out_valid / out_stall) with
// the event code, the held command and length, and for payload bytes the byte
// and its index within the payload.
// Frames are header bytes, a command byte, a big-endian 16-bit length, the
// payload and trailer bytes; patterns come from the two configuration
// registers written through cfg_write, cfg_index and cfg_data.
// The result of a byte is registered in the output buffer by the edge that accepts
// it, and out_valid shows it once it reaches the main entry. Throughput is one byte
// per cycle while in_stall is low; a two-entry output buffer lets the parser
// take a byte while an earlier result waits, and in_stall rises only when both
// entries are occupied by results the receiver has not taken.
// Reset (rst, synchronous) clears both patterns, returns the parser to header
// search with position, command and length cleared, and empties the output
// buffer. While the receiver stalls, the shown result holds steady.
module serial_command_frame_parser #(
  parameter int HEADER_LEN  = scfp_pkg::DEF_HEADER_LEN,
  parameter int TRAILER_LEN = scfp_pkg::DEF_TRAILER_LEN,
  parameter int MAX_PAYLOAD = scfp_pkg::DEF_MAX_PAYLOAD
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [scfp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [scfp_pkg::PATTERN_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [scfp_pkg::BYTE_W-1:0]           rx_byte,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [scfp_pkg::EVENT_W-1:0]          event_res,
  output logic [scfp_pkg::BYTE_W-1:0]           command,
  output logic [scfp_pkg::LENGTH_W-1:0]         payload_length,
  output logic [scfp_pkg::POS_W-1:0]            payload_index,
  output logic [scfp_pkg::BYTE_W-1:0]           payload_byte
);
  import scfp_pkg::*;

  localparam logic [POS_W-1:0]    HEAD_LAST = POS_W'(HEADER_LEN - 1);
  localparam logic [POS_W-1:0]    HEAD_CNT  = POS_W'(HEADER_LEN);
  localparam logic [POS_W-1:0]    TAIL_CNT  = POS_W'(TRAILER_LEN);
  localparam logic [POS_W:0]      DATA_CNT  = (POS_W + 1)'(MAX_PAYLOAD);
  localparam logic [LENGTH_W-1:0] LEN_LIMIT = LENGTH_W'(MAX_PAYLOAD);

  logic [PATTERN_W-1:0] header_pattern;
  logic [PATTERN_W-1:0] trailer_pattern;
  phase_t               phase;
  phase_t               phase_next;
  logic [POS_W-1:0]     position;
  logic [POS_W-1:0]     position_next;
  logic [BYTE_W-1:0]    held_command;
  logic [BYTE_W-1:0]    held_command_next;
  logic [LENGTH_W-1:0]  held_length;
  logic [LENGTH_W-1:0]  held_length_next;

  logic                 accept;
  logic [POS_W-1:0]     pos_head;
  logic [POS_W-1:0]     pos_tail;
  logic [POS_W-1:0]     pos_data;
  logic [POS_W-1:0]     pos_tail_inc;
  logic [LENGTH_W-1:0]  full_length;
  result_t              result;

  assign accept = in_valid && !in_stall;

  // A position at or beyond the phase's count starts over at zero.
  assign pos_head     = (position >= HEAD_CNT) ? '0 : position;
  assign pos_tail     = (position >= TAIL_CNT) ? '0 : position;
  assign pos_data     = ({1'b0, position} >= DATA_CNT) ? '0 : position;
  assign pos_tail_inc = pos_tail + POS_W'(1);
  assign full_length  = {held_length[BYTE_W-1:0], rx_byte};

  always_comb begin
    phase_next        = phase;
    position_next     = position;
    held_command_next = held_command;
    held_length_next  = held_length;
    unique case (phase)
      PH_HEAD: begin
        if (rx_byte == pattern_byte(header_pattern, pos_head[1:0])) begin
          if (pos_head == HEAD_LAST) begin
            position_next = '0;
            phase_next    = PH_CMD;
          end else begin
            position_next = pos_head + POS_W'(1);
          end
        end else begin
          position_next = '0;
        end
      end
      PH_CMD: begin
        held_command_next = rx_byte;
        phase_next        = PH_LEN;
      end
      PH_LEN: begin
        if (position == '0 || position >= POS_W'(2)) begin
          held_length_next = {{(LENGTH_W - BYTE_W){1'b0}}, rx_byte};
          position_next    = POS_W'(1);
        end else begin
          held_length_next = full_length;
          position_next    = '0;
          if (full_length == '0) begin
            phase_next = PH_TAIL;
          end else if (full_length >= LEN_LIMIT) begin
            phase_next = PH_HEAD;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (held_length != '0 &&
            {{(LENGTH_W - POS_W){1'b0}}, pos_data} < held_length - LENGTH_W'(1)) begin
          position_next = pos_data + POS_W'(1);
        end else begin
          phase_next    = PH_TAIL;
          position_next = '0;
        end
      end
      PH_TAIL: begin
        if (rx_byte == pattern_byte(trailer_pattern, pos_tail[1:0])) begin
          if (pos_tail_inc == TAIL_CNT) begin
            position_next = '0;
            phase_next    = PH_HEAD;
          end else begin
            position_next = pos_tail_inc;
          end
        end else begin
          position_next = '0;
          phase_next    = PH_HEAD;
        end
      end
      default: begin
        position_next = '0;
        phase_next    = PH_HEAD;
      end
    endcase
  end

  always_comb begin
    result.event_res      = EV_NONE;
    result.command        = held_command_next;
    result.payload_length = held_length_next;
    result.payload_index  = '0;
    result.payload_byte   = '0;
    unique case (phase)
      PH_LEN: begin
        if (position == POS_W'(1) && full_length != '0 && full_length >= LEN_LIMIT) begin
          result.event_res = EV_TOOLONG;
        end
      end
      PH_DATA: begin
        result.event_res     = EV_DATA;
        result.payload_index = pos_data;
        result.payload_byte  = rx_byte;
      end
      PH_TAIL: begin
        if (rx_byte != pattern_byte(trailer_pattern, pos_tail[1:0])) begin
          result.event_res = EV_BADTAIL;
        end else if (pos_tail_inc == TAIL_CNT) begin
          result.event_res = EV_DONE;
        end
      end
      default: begin
        result.event_res = EV_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_pattern  <= '0;
      trailer_pattern <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HEADER:  header_pattern  <= cfg_data;
        REG_TRAILER: trailer_pattern <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEAD;
      position     <= '0;
      held_command <= '0;
      held_length  <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      position     <= position_next;
      held_command <= held_command_next;
      held_length  <= held_length_next;
    end
  end

  result_t out_data;

  scfp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .full      (in_stall),
    .push_data (result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign event_res      = out_data.event_res;
  assign command        = out_data.command;
  assign payload_length = out_data.payload_length;
  assign payload_index  = out_data.payload_index;
  assign payload_byte   = out_data.payload_byte;

endmodule
